// File: rtl/lms_pkg.sv
// ----------------------------------------------------------------------------
// lms_pkg
// Shared types, codes and timing constants for the LCD line mode sequencer.
// ----------------------------------------------------------------------------
package lms_pkg;

  // Line and frame timing, in ticks and lines
  localparam logic [7:0] SCAN_TICKS    = 8'd40;
  localparam logic [7:0] DRAW_TICKS    = 8'd86;
  localparam logic [7:0] HBLANK_TICKS  = 8'd102;
  localparam logic [7:0] LINE_TICKS    = 8'd228;
  localparam logic [7:0] VISIBLE_LINES = 8'd144;
  localparam logic [7:0] BLANK_LINES   = 8'd10;
  localparam logic [7:0] TOTAL_LINES   = VISIBLE_LINES + BLANK_LINES;
  localparam logic [7:0] LAST_LINE     = TOTAL_LINES - 8'd1;
  localparam logic [7:0] EARLY_DELAY   = 8'(4 / 2);

  // Operation codes
  localparam logic [2:0] OP_TICK        = 3'd0;
  localparam logic [2:0] OP_WR_CONTROL  = 3'd1;
  localparam logic [2:0] OP_WR_STATUS   = 3'd2;
  localparam logic [2:0] OP_WR_COMPARE  = 3'd3;
  localparam logic [2:0] OP_WR_WINDOW_Y = 3'd4;

  // Phase codes
  localparam logic [1:0] PH_HBLANK = 2'd0;
  localparam logic [1:0] PH_VBLANK = 2'd1;
  localparam logic [1:0] PH_SCAN   = 2'd2;
  localparam logic [1:0] PH_DRAW   = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_SPEED = 1'd1;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] write_value;
    logic       frame_wanted;
  } lms_item_t;

  typedef struct packed {
    logic [7:0] current_line;
    logic [6:0] status_read;
    logic       status_irq;
    logic       vblank_irq;
    logic       frame_ready;
    logic       window_armed;
  } lms_result_t;

  typedef struct packed {
    logic       display_on;
    logic [1:0] phase;
    logic [7:0] line_counter;
    logic [7:0] tick_in_line;
    logic [3:0] irq_enables;
    logic [7:0] compare_line;
    logic       coincidence;
    logic       irq_line_level;
    logic [7:0] window_line;
    logic       window_hit;
    logic       first_frame;
    logic       vblank_pending;
  } lms_state_t;

  // Level of the status interrupt line for a given state
  function automatic logic irq_level(lms_state_t st);
    logic lvl;
    lvl = 1'b0;
    if (st.irq_enables[3] && (st.compare_line == st.line_counter)) lvl = 1'b1;
    if ((st.phase == PH_HBLANK) && st.irq_enables[0]) lvl = 1'b1;
    if ((st.phase == PH_VBLANK) && st.irq_enables[1]) lvl = 1'b1;
    if ((st.phase == PH_SCAN) && st.irq_enables[2]) lvl = 1'b1;
    return lvl;
  endfunction

endpackage

// File: rtl/lms_item_if.sv
// ----------------------------------------------------------------------------
// lms_item_if
// Input item channel: one tick or one register write per item.
// ----------------------------------------------------------------------------
interface lms_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] write_value;
  logic       frame_wanted;

  modport source (output valid, operation, write_value, frame_wanted, input ready);
  modport sink (input valid, operation, write_value, frame_wanted, output ready);
endinterface

// File: rtl/lms_result_if.sv
// ----------------------------------------------------------------------------
// lms_result_if
// Result item channel: line, status and interrupt pulses per input item.
// ----------------------------------------------------------------------------
interface lms_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] current_line;
  logic [6:0] status_read;
  logic       status_irq;
  logic       vblank_irq;
  logic       frame_ready;
  logic       window_armed;

  modport source (output valid, current_line, status_read, status_irq, vblank_irq,
                  frame_ready, window_armed, input ready);
  modport sink (input valid, current_line, status_read, status_irq, vblank_irq,
                frame_ready, window_armed, output ready);
endinterface

// File: rtl/lms_cfg_if.sv
// ----------------------------------------------------------------------------
// lms_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lms_cfg_if;
  import lms_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic                 data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/lms_step.sv
// ----------------------------------------------------------------------------
// lms_step
// Next-state and result logic for one item: phase timing, line counter,
// interrupt generation and frame ready.
// ----------------------------------------------------------------------------
module lms_step import lms_pkg::*; (
  input  lms_state_t  state,
  input  lms_item_t   item,
  input  logic        color_mode,
  input  logic        double_speed,
  output lms_state_t  state_next,
  output lms_result_t result
);

  lms_state_t s;
  logic       lvl;
  logic       sirq;
  logic       virq;
  logic       frame;
  logic [7:0] t;
  logic [7:0] len;

  always_comb begin
    s     = state;
    sirq  = 1'b0;
    virq  = 1'b0;
    frame = 1'b0;
    lvl   = 1'b0;
    t     = 8'd0;
    len   = LINE_TICKS;

    unique case (item.operation)
      OP_TICK: begin
        if (s.display_on) begin
          t = s.tick_in_line + 8'd1;
          s.tick_in_line = t;
          // delayed vblank irq and early wrap of the last line
          if ((s.phase == PH_VBLANK) && (t == EARLY_DELAY)) begin
            if (s.vblank_pending) begin
              s.vblank_pending = 1'b0;
              virq = 1'b1;
            end
            if (s.line_counter == LAST_LINE) begin
              s.line_counter = 8'd0;
              s.coincidence  = (s.compare_line == 8'd0);
              lvl  = irq_level(s);
              sirq = sirq | (lvl & ~s.irq_line_level);
              s.irq_line_level = lvl;
            end
          end
          case (s.phase)
            PH_SCAN:   len = SCAN_TICKS;
            PH_DRAW:   len = DRAW_TICKS;
            PH_HBLANK: len = HBLANK_TICKS;
            default:   len = LINE_TICKS;
          endcase
          // end of phase
          if (t >= len) begin
            s.tick_in_line = 8'd0;
            if (s.phase == PH_SCAN) begin
              s.phase = PH_DRAW;
              lvl  = irq_level(s);
              sirq = sirq | (lvl & ~s.irq_line_level);
              s.irq_line_level = lvl;
            end else if (s.phase == PH_DRAW) begin
              s.phase = PH_HBLANK;
              lvl  = irq_level(s);
              sirq = sirq | (lvl & ~s.irq_line_level);
              s.irq_line_level = lvl;
            end else begin
              // new line; skip the increment after the early wrap
              if (!((s.line_counter == 8'd0) && (s.phase == PH_VBLANK))) begin
                s.line_counter = (s.line_counter == LAST_LINE) ? 8'd0
                                                               : s.line_counter + 8'd1;
              end
              if (s.line_counter == VISIBLE_LINES) begin
                s.window_hit = 1'b0;
                s.phase      = PH_VBLANK;
                if (!color_mode || double_speed) s.vblank_pending = 1'b1;
                else virq = 1'b1;
                if (s.first_frame) s.first_frame = 1'b0;
                else if (item.frame_wanted) frame = 1'b1;
              end else if (s.line_counter < VISIBLE_LINES) begin
                s.phase = PH_SCAN;
                if (!s.window_hit && (s.window_line == s.line_counter)) s.window_hit = 1'b1;
              end
              s.coincidence = (s.compare_line == s.line_counter);
              lvl  = irq_level(s);
              sirq = sirq | (lvl & ~s.irq_line_level);
              s.irq_line_level = lvl;
            end
          end
        end
      end
      OP_WR_CONTROL: begin
        if (!s.display_on && item.write_value[7]) begin
          s.display_on   = 1'b1;
          s.first_frame  = 1'b1;
          s.phase        = PH_SCAN;
          s.tick_in_line = 8'd0;
          lvl  = irq_level(s);
          sirq = sirq | (lvl & ~s.irq_line_level);
          s.irq_line_level = lvl;
        end else if (s.display_on && !item.write_value[7]) begin
          s.display_on     = 1'b0;
          s.phase          = PH_HBLANK;
          s.tick_in_line   = 8'd0;
          s.vblank_pending = 1'b0;
          s.window_hit     = 1'b0;
          s.irq_line_level = 1'b0;
          s.line_counter   = 8'd0;
          frame            = 1'b1;
        end
      end
      OP_WR_STATUS: begin
        s.irq_enables = item.write_value[6:3];
        lvl  = irq_level(s);
        sirq = sirq | (lvl & ~s.irq_line_level);
        s.irq_line_level = lvl;
      end
      OP_WR_COMPARE: begin
        s.compare_line = item.write_value;
        lvl  = irq_level(s);
        sirq = sirq | (lvl & ~s.irq_line_level);
        s.irq_line_level = lvl;
      end
      OP_WR_WINDOW_Y: begin
        s.window_line = item.write_value;
      end
      default: begin
      end
    endcase
  end

  assign state_next = s;
  assign result     = '{current_line: s.line_counter,
                        status_read:  {s.irq_enables, s.coincidence, s.phase},
                        status_irq:   sirq,
                        vblank_irq:   virq,
                        frame_ready:  frame,
                        window_armed: s.window_hit};

endmodule

// File: rtl/lcd_line_mode_sequencer_unit.sv
// ----------------------------------------------------------------------------
// lcd_line_mode_sequencer_unit
// LCD line mode sequencer: steps scan, draw, hblank and vblank phases on
// ticks, counts lines and raises status, vblank and frame ready pulses.
// ----------------------------------------------------------------------------
// Path: an accepted item waits in the input register, then takes a single pass of
//   the step logic into the result register; a stalled result holds it there.
// Throughput: 1 item per cycle while results are taken; the sequencer state updates once per item.
// Reset (rst, synchronous): display off, hblank, line 0, all enables and
//   compare/window registers cleared; both pipeline registers empty.
// ----------------------------------------------------------------------------
module lcd_line_mode_sequencer_unit import lms_pkg::*; (
  input logic         clk,
  input logic         rst,
  lms_item_if.sink    item_in,
  lms_result_if.source result_out,
  lms_cfg_if.sink     cfg
);

  logic        item_valid;
  lms_item_t   item;
  logic        advance;
  lms_state_t  state;
  lms_state_t  state_next;
  lms_result_t step_result;
  lms_result_t result;
  logic        result_valid;
  logic        color_mode;
  logic        double_speed;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode   <= 1'b0;
      double_speed <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_COLOR_MODE:   color_mode   <= cfg.data;
        CFG_DOUBLE_SPEED: double_speed <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Input register
  assign advance       = item_valid && (!result_valid || result_out.ready);
  assign item_in.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_in.ready) begin
      item_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.ready && item_in.valid) begin
      item <= '{operation:    item_in.operation,
                write_value:  item_in.write_value,
                frame_wanted: item_in.frame_wanted};
    end
  end

  // Step logic
  lms_step u_step (
    .state        (state),
    .item         (item),
    .color_mode   (color_mode),
    .double_speed (double_speed),
    .state_next   (state_next),
    .result       (step_result)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_out.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  assign result_out.valid        = result_valid;
  assign result_out.current_line = result.current_line;
  assign result_out.status_read  = result.status_read;
  assign result_out.status_irq   = result.status_irq;
  assign result_out.vblank_irq   = result.vblank_irq;
  assign result_out.frame_ready  = result.frame_ready;
  assign result_out.window_armed = result.window_armed;

endmodule
